FILE: rtl/mcfr_pkg.sv
// Shared types and constants of the motor command frame receiver.
package mcfr_pkg;

  // Control byte layout: direction in the top bit, duty below it.
  localparam int unsigned CmdW  = 8;
  localparam int unsigned DutyW = 7;
  localparam int unsigned DirBit = 7;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_FAST_DECAY = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_START_BYTE = 1'd1;

  localparam logic [CmdW-1:0] START_BYTE_RESET = 8'h7F;

  // Drive mode of one H-bridge input.
  typedef enum logic [1:0] {
    MODE_LOW  = 2'd0,
    MODE_HIGH = 2'd1,
    MODE_PWM  = 2'd2
  } mode_e;

  // What the parser hands to the result stage for one processed beat.
  typedef struct packed {
    logic            valid;      // this beat closed a frame
    logic            status;     // 1: checksum mismatch, command kept
    logic [CmdW-1:0] left_cmd;   // command in force after the frame
    logic [CmdW-1:0] right_cmd;
  } frame_done_t;

endpackage

FILE: rtl/motor_command_frame_receiver.sv
// Top level of the motor command frame receiver.
// A checksum beat is held in the input register, its result in the result register.
// Throughput: one received byte per cycle. While a result waits, the input register
// holds one further beat and then the input stalls until the result is taken.
// Only checksum beats produce a result; all other beats just advance the parser.
// Reset (asynchronous, active low) returns the parser to the start byte hunt, clears
// both commands to reverse with zero duty, slow decay, and start byte 0x7F.
module motor_command_frame_receiver
  import mcfr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CmdW-1:0]    cfg_data_i,
  // Received byte channel
  input  logic               rx_valid_i,
  output logic               rx_ready_o,
  input  logic [CmdW-1:0]    rx_byte_i,
  // Result channel
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic               status_o,
  output logic [DutyW-1:0]   left_duty_o,
  output logic [DutyW-1:0]   right_duty_o,
  output logic [1:0]         left_in1_mode_o,
  output logic [1:0]         left_in2_mode_o,
  output logic [1:0]         right_in1_mode_o,
  output logic [1:0]         right_in2_mode_o
);

  // Configuration registers. Writes are always taken at once.
  logic            fast_decay_q;
  logic [CmdW-1:0] start_byte_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_decay_q <= 1'b0;
      start_byte_q <= START_BYTE_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FAST_DECAY: fast_decay_q <= cfg_data_i[0];
        CFG_START_BYTE: start_byte_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register. The held beat moves on whenever the result register is empty or
  // its result is being taken in the same cycle, whether or not the beat closes a
  // frame; so an incoming beat is refused only while a result stalls behind it.
  logic            in_valid_q, in_valid_d;
  logic [CmdW-1:0] in_byte_q;
  logic            advance;
  logic            rx_take;
  frame_done_t     done;

  assign advance    = ~res_valid_o | res_ready_i;
  assign rx_ready_o = ~in_valid_q | advance;
  assign rx_take    = rx_valid_i & rx_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (rx_take)      in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_take) in_byte_q <= rx_byte_i;
  end

  // Parser state advances in the same cycle that the beat leaves the input register.
  mcfr_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (in_valid_q & advance),
    .byte_i       (in_byte_q),
    .start_byte_i (start_byte_q),
    .done_o       (done)
  );

  // Result register: loads on every advance, empty when the beat closed no frame.
  mcfr_result u_result (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (advance),
    .done_i           (done),
    .fast_decay_i     (fast_decay_q),
    .valid_o          (res_valid_o),
    .status_o         (status_o),
    .left_duty_o      (left_duty_o),
    .right_duty_o     (right_duty_o),
    .left_in1_mode_o  (left_in1_mode_o),
    .left_in2_mode_o  (left_in2_mode_o),
    .right_in1_mode_o (right_in1_mode_o),
    .right_in2_mode_o (right_in2_mode_o)
  );

endmodule

FILE: rtl/mcfr_parser.sv
// Frame parser: start byte hunt, control byte capture, checksum and command store.
module mcfr_parser
  import mcfr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [CmdW-1:0]   byte_i,
  input  logic [CmdW-1:0]   start_byte_i,
  output frame_done_t       done_o
);

  localparam logic [1:0] PH_HUNT  = 2'd0;
  localparam logic [1:0] PH_LEFT  = 2'd1;
  localparam logic [1:0] PH_RIGHT = 2'd2;
  localparam logic [1:0] PH_CHECK = 2'd3;

  logic [1:0]      phase_q, phase_d;
  logic [CmdW-1:0] left_pend_q, left_pend_d;
  logic [CmdW-1:0] right_pend_q, right_pend_d;
  logic [CmdW-1:0] left_cmd_q, left_cmd_d;
  logic [CmdW-1:0] right_cmd_q, right_cmd_d;
  logic [CmdW-1:0] expect_sum;
  logic            match;

  // The checksum is the inverted 8-bit wrapping sum of both control bytes.
  assign expect_sum = ~(left_pend_q + right_pend_q);
  assign match      = (byte_i == expect_sum);

  always_comb begin
    phase_d      = phase_q;
    left_pend_d  = left_pend_q;
    right_pend_d = right_pend_q;
    left_cmd_d   = left_cmd_q;
    right_cmd_d  = right_cmd_q;
    done_o       = '0;
    done_o.left_cmd  = left_cmd_q;
    done_o.right_cmd = right_cmd_q;
    if (step_i) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (byte_i == start_byte_i) phase_d = PH_LEFT;
        end
        PH_LEFT: begin
          left_pend_d = byte_i;
          phase_d     = PH_RIGHT;
        end
        PH_RIGHT: begin
          right_pend_d = byte_i;
          phase_d      = PH_CHECK;
        end
        PH_CHECK: begin
          phase_d      = PH_HUNT;
          done_o.valid = 1'b1;
          if (match) begin
            left_cmd_d  = left_pend_q;
            right_cmd_d = right_pend_q;
          end
          done_o.status    = ~match;
          done_o.left_cmd  = left_cmd_d;
          done_o.right_cmd = right_cmd_d;
        end
        default: phase_d = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      left_pend_q  <= '0;
      right_pend_q <= '0;
      left_cmd_q   <= '0;
      right_cmd_q  <= '0;
    end else begin
      phase_q      <= phase_d;
      left_pend_q  <= left_pend_d;
      right_pend_q <= right_pend_d;
      left_cmd_q   <= left_cmd_d;
      right_cmd_q  <= right_cmd_d;
    end
  end

endmodule

FILE: rtl/mcfr_result.sv
// Result register with H-bridge mode decoding.
module mcfr_result
  import mcfr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  frame_done_t        done_i,
  input  logic               fast_decay_i,
  output logic               valid_o,
  output logic               status_o,
  output logic [DutyW-1:0]   left_duty_o,
  output logic [DutyW-1:0]   right_duty_o,
  output logic [1:0]         left_in1_mode_o,
  output logic [1:0]         left_in2_mode_o,
  output logic [1:0]         right_in1_mode_o,
  output logic [1:0]         right_in2_mode_o
);

  // Fast decay puts PWM on the driving input; slow decay holds one input high.
  function automatic mode_e in1_mode(input logic fwd, input logic fast);
    mode_e m;
    if (fast) m = fwd ? MODE_PWM : MODE_LOW;
    else      m = fwd ? MODE_HIGH : MODE_PWM;
    return m;
  endfunction

  function automatic mode_e in2_mode(input logic fwd, input logic fast);
    mode_e m;
    if (fast) m = fwd ? MODE_LOW : MODE_PWM;
    else      m = fwd ? MODE_PWM : MODE_HIGH;
    return m;
  endfunction

  logic             valid_q;
  logic             status_q;
  logic [DutyW-1:0] left_duty_q, right_duty_q;
  mode_e            l1_q, l2_q, r1_q, r2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= done_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && done_i.valid) begin
      status_q     <= done_i.status;
      left_duty_q  <= done_i.left_cmd[DutyW-1:0];
      right_duty_q <= done_i.right_cmd[DutyW-1:0];
      l1_q <= in1_mode(done_i.left_cmd[DirBit], fast_decay_i);
      l2_q <= in2_mode(done_i.left_cmd[DirBit], fast_decay_i);
      r1_q <= in1_mode(done_i.right_cmd[DirBit], fast_decay_i);
      r2_q <= in2_mode(done_i.right_cmd[DirBit], fast_decay_i);
    end
  end

  assign valid_o          = valid_q;
  assign status_o         = status_q;
  assign left_duty_o      = left_duty_q;
  assign right_duty_o     = right_duty_q;
  assign left_in1_mode_o  = 2'(l1_q);
  assign left_in2_mode_o  = 2'(l2_q);
  assign right_in1_mode_o = 2'(r1_q);
  assign right_in2_mode_o = 2'(r2_q);

endmodule

FILE: rtl/mcfr_checker.sv
// Port-level checks for the motor command frame receiver, bound to the top level.
module mcfr_checker
  import mcfr_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             rx_valid_i,
  input logic             rx_ready_o,
  input logic             res_valid_o,
  input logic             res_ready_i,
  input logic             status_o,
  input logic [DutyW-1:0] left_duty_o,
  input logic [DutyW-1:0] right_duty_o,
  input logic [1:0]       left_in1_mode_o,
  input logic [1:0]       left_in2_mode_o,
  input logic [1:0]       right_in1_mode_o,
  input logic [1:0]       right_in2_mode_o
);

  // A stalled result keeps its status and duties.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(status_o)
      && $stable(left_duty_o) && $stable(right_duty_o))
    else $error("result changed while stalled");

  // With no result waiting, the input side must take a beat.
  a_rx_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_o |-> rx_ready_o)
    else $error("input refused with empty result register");

  // A new result follows an accepted beat that passed through the input register.
  a_res_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_o) |-> $past(rx_valid_i && rx_ready_o, 2))
    else $error("result without a matching input beat");

  // Each bridge has exactly one PWM input, and its two inputs differ.
  a_modes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |->
      (left_in1_mode_o != left_in2_mode_o)
      && (left_in1_mode_o == MODE_PWM || left_in2_mode_o == MODE_PWM)
      && (right_in1_mode_o != right_in2_mode_o)
      && (right_in1_mode_o == MODE_PWM || right_in2_mode_o == MODE_PWM))
    else $error("inconsistent bridge modes");

endmodule

bind motor_command_frame_receiver mcfr_checker u_mcfr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .rx_valid_i       (rx_valid_i),
  .rx_ready_o       (rx_ready_o),
  .res_valid_o      (res_valid_o),
  .res_ready_i      (res_ready_i),
  .status_o         (status_o),
  .left_duty_o      (left_duty_o),
  .right_duty_o     (right_duty_o),
  .left_in1_mode_o  (left_in1_mode_o),
  .left_in2_mode_o  (left_in2_mode_o),
  .right_in1_mode_o (right_in1_mode_o),
  .right_in2_mode_o (right_in2_mode_o)
);
